/* hdl/raw_opl_command_stream_player_assert.svh */
// Assertion macros for the raw OPL command stream player.
// Included by the modules that check their own logic; no other dependencies.
`ifndef RAW_OPL_COMMAND_STREAM_PLAYER_ASSERT_SVH
`define RAW_OPL_COMMAND_STREAM_PLAYER_ASSERT_SVH
`ifndef ASSERT_OFF
`define ROCSP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define ROCSP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define ROCSP_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define ROCSP_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

/* hdl/rocsp_pkg.sv */
// Shared types and code constants for the raw OPL command stream player.
// No dependencies.
package rocsp_pkg;

  localparam int BYTE_W      = 8;
  localparam int CLK_W       = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 5;

  localparam logic                REQ_TICK      = 1'b0;
  localparam logic [BYTE_W-1:0]   CMD_DELAY     = 8'h00;
  localparam logic [BYTE_W-1:0]   CMD_CTRL      = 8'h02;
  localparam logic [BYTE_W-1:0]   CMD_SKIP_LO   = 8'h03;
  localparam logic [BYTE_W-1:0]   CMD_SKIP_HI   = 8'h04;
  localparam logic [BYTE_W-1:0]   CMD_END       = 8'hFF;
  localparam logic [BYTE_W-1:0]   PRM_END       = 8'hFF;
  localparam logic [BYTE_W-1:0]   PRM_CLOCK     = 8'h00;
  localparam logic [BYTE_W-1:0]   PRM_BANK_HIGH = 8'h02;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] cmd_byte;
    logic [BYTE_W-1:0] param_byte;
  } item_t;

  typedef struct packed {
    logic              opl_write;
    logic              opl_bank;
    logic [BYTE_W-1:0] opl_reg;
    logic [BYTE_W-1:0] opl_data;
    logic              speed_write;
    logic [CLK_W-1:0]  speed_value;
    logic              burst_done;
    logic              want_data;
    logic              song_end;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

/* hdl/raw_opl_command_stream_player.sv */
// Top level of the raw OPL command stream player: input stage, decode, output stage.
// Depends on rocsp_pkg, rocsp_in_stage, rocsp_decode and rocsp_out_stage.
//
//  channel | direction | contents
//  in_*    | slave     | tick or command/parameter pair, one per transaction
//  out_*   | master    | one result per input transaction, same order
//  cfg_*   | write     | initial clock divisor
//
// One transaction per cycle sustained while out_tready stays high; an output stall holds the flow.
// A transaction passes the input register, the pair decode and then the output register.
// Reset clears all flags, the delay counter and the clock divisor to zero.
// A stalled output holds its result; the input stage refills while the output drains.
module raw_opl_command_stream_player (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] cmd_byte, [15:8] param_byte
  input  logic [rocsp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] req_type
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] opl_bank, [8:1] opl_reg, [16:9] opl_data, [32:17] speed_value, [39:33] zero
  output logic [rocsp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] opl_write, [1] speed_write, [2] burst_done, [3] want_data, [4] song_end
  output logic [rocsp_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input  logic                                cfg_we,
  input  logic [rocsp_pkg::CLK_W-1:0]         cfg_wdata
);
  import rocsp_pkg::*;

  item_t   in_item;
  stage_t  stage;
  result_t dec_res;
  result_t out_res;
  logic    load;

  assign in_item.req_type   = in_tuser;
  assign in_item.cmd_byte   = in_tdata[BYTE_W-1:0];
  assign in_item.param_byte = in_tdata[2*BYTE_W-1:BYTE_W];

  rocsp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .advance   (load),
    .stage     (stage)
  );

  rocsp_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (stage.item),
    .fire      (load),
    .res       (dec_res)
  );

  rocsp_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_valid  (stage.valid),
    .src_res    (dec_res),
    .load       (load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {7'd0, out_res.speed_value, out_res.opl_data, out_res.opl_reg,
                      out_res.opl_bank};
  assign out_tuser = {out_res.song_end, out_res.want_data, out_res.burst_done,
                      out_res.speed_write, out_res.opl_write};

endmodule

/* hdl/rocsp_in_stage.sv */
// Input register stage: holds one accepted command/tick transaction.
// Depends on rocsp_pkg.
module rocsp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  rocsp_pkg::item_t in_item,
  input  logic            advance,
  output rocsp_pkg::stage_t stage
);
  import rocsp_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

/* hdl/rocsp_decode.sv */
// Player state and single-pass decode of one command pair or tick.
// Depends on rocsp_pkg and raw_opl_command_stream_player_assert.svh.
`include "raw_opl_command_stream_player_assert.svh"
module rocsp_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rocsp_pkg::CLK_W-1:0]   cfg_wdata,
  input  rocsp_pkg::item_t              item,
  input  logic                          fire,
  output rocsp_pkg::result_t            res
);
  import rocsp_pkg::*;

  logic [BYTE_W-1:0] delay_left_r, delay_left_nxt;
  logic              bank_high_r, bank_high_nxt;
  logic              clock_pending_r, clock_pending_nxt;
  logic [CLK_W-1:0]  clock_divisor_r, clock_divisor_nxt;
  logic              finished_r, finished_nxt;

  always_comb begin
    delay_left_nxt    = delay_left_r;
    bank_high_nxt     = bank_high_r;
    clock_pending_nxt = clock_pending_r;
    clock_divisor_nxt = clock_divisor_r;
    finished_nxt      = finished_r;
    res               = '0;
    if (!finished_r) begin
      if (item.req_type == REQ_TICK) begin
        if (delay_left_r != '0) begin
          delay_left_nxt = delay_left_r - BYTE_W'(1);
        end else begin
          res.want_data = 1'b1;
        end
      end else if (clock_pending_r) begin
        clock_divisor_nxt = {item.cmd_byte, item.param_byte};
        clock_pending_nxt = 1'b0;
        res.speed_write   = 1'b1;
      end else if (item.cmd_byte == CMD_DELAY) begin
        delay_left_nxt = item.param_byte - BYTE_W'(1);
        res.burst_done = 1'b1;
      end else if (item.cmd_byte == CMD_CTRL) begin
        if (item.param_byte == PRM_CLOCK) begin
          clock_pending_nxt = 1'b1;
        end else begin
          bank_high_nxt = (item.param_byte == PRM_BANK_HIGH);
        end
      end else if (item.cmd_byte == CMD_SKIP_LO || item.cmd_byte == CMD_SKIP_HI) begin
        res.opl_write = 1'b0;
      end else if (item.cmd_byte == CMD_END) begin
        if (item.param_byte == PRM_END) begin
          finished_nxt = 1'b1;
        end
      end else begin
        res.opl_write = 1'b1;
        res.opl_reg   = item.cmd_byte;
        res.opl_data  = item.param_byte;
      end
    end
    res.opl_bank    = bank_high_nxt;
    res.speed_value = clock_divisor_nxt;
    res.song_end    = finished_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_left_r    <= '0;
      bank_high_r     <= 1'b0;
      clock_pending_r <= 1'b0;
      clock_divisor_r <= '0;
      finished_r      <= 1'b0;
    end else if (cfg_we) begin
      clock_divisor_r <= cfg_wdata;
    end else if (fire) begin
      delay_left_r    <= delay_left_nxt;
      bank_high_r     <= bank_high_nxt;
      clock_pending_r <= clock_pending_nxt;
      clock_divisor_r <= clock_divisor_nxt;
      finished_r      <= finished_nxt;
    end
  end

  `ROCSP_ASSERT(a_finished_sticky, clk, rst_n, finished_r |=> finished_r, "song end flag dropped")
  `ROCSP_ASSERT(a_no_write_after_end, clk, rst_n, finished_r |-> (!res.opl_write && !res.want_data && !res.speed_write), "activity after song end")
  `ROCSP_ASSERT(a_one_kind, clk, rst_n, $onehot0({res.opl_write, res.speed_write, res.burst_done, res.want_data}), "result carries more than one kind")
  `ROCSP_ASSERT(a_clock_consumed, clk, rst_n, (fire && !cfg_we && clock_pending_r && !finished_r && item.req_type != REQ_TICK) |=> (!clock_pending_r && $past(res.speed_write)), "pending divisor not consumed")

endmodule

/* hdl/rocsp_out_stage.sv */
// Output register stage: holds one result transaction until taken.
// Depends on rocsp_pkg.
module rocsp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              src_valid,
  input  rocsp_pkg::result_t src_res,
  output logic              load,
  output logic              out_tvalid,
  input  logic              out_tready,
  output rocsp_pkg::result_t out_res
);
  import rocsp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign load = src_valid && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= src_res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

/* tb/tb_raw_opl_command_stream_player.sv */
// Self-checking testbench for raw_opl_command_stream_player: directed decode, random streams,
// output back-pressure and song end, each result checked against an in-bench player model.
// Depends on rocsp_pkg and the player RTL only.
module tb_raw_opl_command_stream_player;
  import rocsp_pkg::*;

  localparam logic   REQ_PAIR      = 1'b1;
  localparam int     LATENCY       = 2;
  localparam int     MAX_GAP       = 17;
  localparam int     RANDOM_ITEMS  = 1400;
  localparam int     RANDOM_PHASES = 7;
  localparam int     HOLD_CYCLES   = 300;
  localparam longint CYCLE_LIMIT   = 400000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CLK_W-1:0]       cfg_wdata  = '0;

  logic [BYTE_W-1:0] delay_cnt   = '0;
  logic              bank_hi     = 1'b0;
  logic              divisor_due = 1'b0;
  logic [CLK_W-1:0]  divisor     = '0;
  logic              ended       = 1'b0;

  result_t predicted_results[$];
  bit      gaps_on      = 1'b1;
  int      hold_left    = 0;
  int      items_sent   = 0;
  int      results_seen = 0;
  int      cfg_writes   = 0;
  int      mismatches   = 0;
  longint  cycle_cnt    = 0;

  raw_opl_command_stream_player u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic item_t mk_item(input logic req, input logic [BYTE_W-1:0] c,
                                    input logic [BYTE_W-1:0] p);
    item_t it;
    it.req_type   = req;
    it.cmd_byte   = c;
    it.param_byte = p;
    return it;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it = mk_item(1'($urandom_range(0, 1)), BYTE_W'($urandom), BYTE_W'($urandom));
    if (it.req_type == REQ_PAIR && it.cmd_byte == CMD_END && it.param_byte == PRM_END) begin
      it.param_byte[0] = 1'b0;
    end
    return it;
  endfunction

  // Advance the player state by one transaction and return its result.
  function automatic result_t play_item(input item_t it);
    result_t r;
    r = '0;
    if (!ended) begin
      if (it.req_type == REQ_TICK) begin
        if (delay_cnt != '0) delay_cnt = delay_cnt - BYTE_W'(1);
        else r.want_data = 1'b1;
      end else if (divisor_due) begin
        divisor     = {it.cmd_byte, it.param_byte};
        divisor_due = 1'b0;
        r.speed_write = 1'b1;
      end else begin
        case (it.cmd_byte)
          CMD_DELAY: begin
            delay_cnt    = it.param_byte - BYTE_W'(1);
            r.burst_done = 1'b1;
          end
          CMD_CTRL: begin
            if (it.param_byte == PRM_CLOCK) divisor_due = 1'b1;
            else bank_hi = (it.param_byte == PRM_BANK_HIGH);
          end
          CMD_SKIP_LO, CMD_SKIP_HI: ;
          CMD_END: begin
            if (it.param_byte == PRM_END) ended = 1'b1;
          end
          default: begin
            r.opl_write = 1'b1;
            r.opl_reg   = it.cmd_byte;
            r.opl_data  = it.param_byte;
          end
        endcase
      end
    end
    r.opl_bank    = bank_hi;
    r.speed_value = divisor;
    r.song_end    = ended;
    return r;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.req_type;
    in_tdata  <= {it.param_byte, it.cmd_byte};
    do @(posedge clk); while (!in_tready);
    predicted_results.push_back(play_item(it));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  task automatic write_initial_clock(input logic [CLK_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    divisor = v;
    cfg_writes++;
  endtask

  // Send a burst of pairs and occasional ticks as a capture would hold it, closed by a delay.
  task automatic send_burst(input int n_pairs);
    int                kind;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] p;
    repeat (n_pairs) begin
      kind = $urandom_range(0, 19);
      p    = BYTE_W'($urandom);
      if (kind < 12) begin
        do c = BYTE_W'($urandom);
        while (c == CMD_DELAY || c == CMD_CTRL || c == CMD_SKIP_LO || c == CMD_SKIP_HI ||
               c == CMD_END);
        send_item(mk_item(REQ_PAIR, c, p));
      end else if (kind < 15) begin
        send_item(mk_item(REQ_PAIR, CMD_CTRL, (kind == 12) ? PRM_BANK_HIGH : p));
      end else if (kind < 17) begin
        send_item(mk_item(REQ_PAIR, CMD_CTRL, PRM_CLOCK));
        send_item(mk_item(REQ_PAIR, BYTE_W'($urandom), BYTE_W'($urandom)));
      end else if (kind == 17) begin
        send_item(mk_item(REQ_PAIR, $urandom_range(0, 1) ? CMD_SKIP_HI : CMD_SKIP_LO, p));
      end else if (kind == 18) begin
        send_item(mk_item(REQ_PAIR, CMD_END, {p[BYTE_W-1:1], 1'b0}));
      end else begin
        send_item(mk_item(REQ_TICK, BYTE_W'($urandom), p));
      end
    end
    p = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom) : BYTE_W'($urandom_range(1, 4));
    send_item(mk_item(REQ_PAIR, CMD_DELAY, p));
  endtask

  task automatic report_mismatch(input string what, input logic [CLK_W-1:0] got,
                                 input logic [CLK_W-1:0] want);
    mismatches++;
    $display("cycle %0d result %0d: %s got %h, expected %h",
             cycle_cnt, results_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [CLK_W-1:0] got,
                             input logic [CLK_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] d,
                              input logic [OUT_TUSER_W-1:0] u);
    result_t e;
    if (predicted_results.size() == 0) begin
      report_mismatch("unexpected result", '0, '0);
      return;
    end
    e = predicted_results.pop_front();
    results_seen++;
    check_field("opl_write",   CLK_W'(u[0]),    CLK_W'(e.opl_write));
    check_field("speed_write", CLK_W'(u[1]),    CLK_W'(e.speed_write));
    check_field("burst_done",  CLK_W'(u[2]),    CLK_W'(e.burst_done));
    check_field("want_data",   CLK_W'(u[3]),    CLK_W'(e.want_data));
    check_field("song_end",    CLK_W'(u[4]),    CLK_W'(e.song_end));
    check_field("opl_bank",    CLK_W'(d[0]),    CLK_W'(e.opl_bank));
    check_field("opl_reg",     CLK_W'(d[8:1]),  CLK_W'(e.opl_reg));
    check_field("opl_data",    CLK_W'(d[16:9]), CLK_W'(e.opl_data));
    check_field("speed_value", d[32:17], e.speed_value);
    check_field("tdata pad",   CLK_W'(d[OUT_TDATA_W-1:33]), '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) check_result(out_tdata, out_tuser);
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready) stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      else if (stall > 0) stall--;
      if (hold_left > 0) hold_left--;
      out_tready <= (stall == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, predicted_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed_decode();
    send_item(mk_item(REQ_TICK, '0, '0));
    send_item(mk_item(REQ_PAIR, 8'h01, 8'h00));
    send_item(mk_item(REQ_PAIR, 8'hFE, 8'hFF));
    send_item(mk_item(REQ_PAIR, CMD_CTRL, PRM_BANK_HIGH));
    send_item(mk_item(REQ_PAIR, 8'h80, 8'h5A));
    send_item(mk_item(REQ_PAIR, CMD_CTRL, 8'hFF));
    send_item(mk_item(REQ_PAIR, CMD_CTRL, PRM_BANK_HIGH));
    send_item(mk_item(REQ_PAIR, CMD_CTRL, 8'h01));
    send_item(mk_item(REQ_PAIR, CMD_SKIP_LO, 8'h77));
    send_item(mk_item(REQ_PAIR, CMD_SKIP_HI, 8'hFF));
    send_item(mk_item(REQ_PAIR, CMD_END, 8'hFE));
    send_item(mk_item(REQ_PAIR, CMD_CTRL, PRM_CLOCK));
    send_item(mk_item(REQ_TICK, '0, '0));
    send_item(mk_item(REQ_PAIR, CMD_END, PRM_END));
    send_item(mk_item(REQ_PAIR, CMD_CTRL, PRM_CLOCK));
    send_item(mk_item(REQ_PAIR, 8'h00, 8'h00));
    send_item(mk_item(REQ_PAIR, CMD_DELAY, 8'h00));
    send_item(mk_item(REQ_TICK, '0, '0));
    send_item(mk_item(REQ_PAIR, 8'h20, 8'h01));
    send_item(mk_item(REQ_PAIR, CMD_DELAY, 8'h01));
    send_item(mk_item(REQ_TICK, '0, '0));
    send_item(mk_item(REQ_PAIR, CMD_DELAY, 8'h03));
  endtask

  task automatic test_random_stream();
    int               ph;
    int               start;
    logic [CLK_W-1:0] init_clk;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       init_clk = '1;
        1:       init_clk = '0;
        2:       init_clk = 16'h8000;
        3:       init_clk = 16'h0001;
        default: init_clk = CLK_W'($urandom);
      endcase
      write_initial_clock(init_clk);
      gaps_on = (ph % 3 != 1);
      start   = items_sent;
      while (items_sent - start < RANDOM_ITEMS / RANDOM_PHASES) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) send_item(noise_item());
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_item(mk_item(REQ_TICK, BYTE_W'($urandom), BYTE_W'($urandom)));
          end
          send_burst($urandom_range(0, 8));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    gaps_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (6) send_burst(6);
    gaps_on = 1'b1;
  endtask

  task automatic test_song_end();
    send_item(mk_item(REQ_PAIR, CMD_CTRL, PRM_BANK_HIGH));
    send_item(mk_item(REQ_PAIR, CMD_DELAY, 8'h04));
    send_item(mk_item(REQ_PAIR, CMD_END, PRM_END));
    send_item(mk_item(REQ_TICK, '0, '0));
    send_item(mk_item(REQ_PAIR, 8'h40, 8'h3F));
    send_item(mk_item(REQ_PAIR, CMD_CTRL, PRM_CLOCK));
    send_item(mk_item(REQ_PAIR, CMD_CTRL, 8'h01));
    send_item(mk_item(REQ_PAIR, CMD_DELAY, 8'h00));
    write_initial_clock(16'h4321);
    send_item(mk_item(REQ_TICK, '0, '0));
    send_item(mk_item(REQ_PAIR, CMD_END, PRM_END));
    repeat (20) send_item(noise_item());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_decode();
    test_random_stream();
    test_backpressure();
    test_song_end();
    wait_idle();
    $display("sent %0d transactions, checked %0d results, %0d clock divisor writes",
             items_sent, results_seen, cfg_writes);
    $display("covered directed decode, %0d random phases, output hold-off and song end",
             RANDOM_PHASES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
